@@ hw/rtl/amf_pkg.sv @@
// shared types and constants for the arx model filter
`default_nettype none

package amf_pkg;

   localparam int SAMPLE_W = 24;
   localparam int COEF_W   = 18;
   localparam int DELAY_W  = 5;
   localparam int PROD_W   = SAMPLE_W + COEF_W;
   localparam int ACC_W    = 48;
   localparam int FRAC_SHIFT = 16;
   localparam int NUM_COEF = 3;
   localparam int COEF_IDX_W = 2;

   localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(32768);
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 24'h7FFFFF;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 24'h800000;

   // register indexes on the csr port
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_INPUT_COEF_0    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INPUT_COEF_1    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INPUT_COEF_2    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_COEF_1   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_COEF_2   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_COEF_3   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TRANSPORT_DELAY = 3'd6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear;
      logic issue;
      logic sub;
   } mac_ctrl_type;

endpackage

`default_nettype wire

@@ hw/rtl/amf_mac.sv @@
// shared multiply-accumulate unit: registered product, then accumulate
`default_nettype none

module amf_mac (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire amf_pkg::mac_ctrl_type               ctrl,
   input  wire logic signed [amf_pkg::SAMPLE_W-1:0] sample,
   input  wire logic signed [amf_pkg::COEF_W-1:0]   coef,
   output logic signed [amf_pkg::ACC_W-1:0]         acc
);
   import amf_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic                     prod_vld_ff;
   logic                     prod_sub_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  prod_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctrl.issue;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= PROD_W'(sample) * PROD_W'(coef);
      prod_sub_ff <= ctrl.sub;
   end

   assign prod_ext = ACC_W'(prod_ff);

   // clear preloads the rounding bias
   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         acc_ff <= ROUND_BIAS;
      end else if (prod_vld_ff) begin
         if (prod_sub_ff) begin
            acc_ff <= acc_ff - prod_ext;
         end else begin
            acc_ff <= acc_ff + prod_ext;
         end
      end
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

@@ hw/rtl/arx_model_filter_core.sv @@
// top level of the arx plant model: delay line, histories, sequencer
//
//   port group  direction  word
//   req_*       in         control_sample (one sample per word)
//   rsp_*       out        plant_output, saturated (one word per sample)
//   csr_*       in         coefficient and delay writes, no read-back
//
// each sample is worked through its NUM_OUTPUT_TAPS + NUM_INPUT_TAPS taps by the
// single shared multiplier, one tap per cycle.
// req_stall is high from acceptance until the result is loaded into rsp.
// a finished word waits in the rsp register; the next sample is taken meanwhile.
// reset clears coefficients, histories and the delay line fill count at once.
`default_nettype none

module arx_model_filter_core #(
   parameter int MAX_DELAY       = 16,
   parameter int NUM_INPUT_TAPS  = 3,
   parameter int NUM_OUTPUT_TAPS = 3
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [amf_pkg::SAMPLE_W-1:0]  req_control_sample,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [amf_pkg::SAMPLE_W-1:0]       rsp_plant_output,
   output logic                                      rsp_saturated,
   input  wire logic                                 csr_write,
   input  wire logic [amf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [amf_pkg::COEF_W-1:0]           csr_wdata
);
   import amf_pkg::*;

   localparam int PTR_W  = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
   localparam int CNT_W  = $clog2(MAX_DELAY + 1);
   localparam int NUM_TAPS = NUM_INPUT_TAPS + NUM_OUTPUT_TAPS;
   localparam int TAP_W  = $clog2(NUM_TAPS);
   localparam int IH_W   = (NUM_INPUT_TAPS > 1) ? $clog2(NUM_INPUT_TAPS) : 1;
   localparam int OH_W   = (NUM_OUTPUT_TAPS > 1) ? $clog2(NUM_OUTPUT_TAPS) : 1;

   // configuration registers
   logic signed [COEF_W-1:0]  b_coef_ff [NUM_COEF];
   logic signed [COEF_W-1:0]  a_coef_ff [NUM_COEF];
   logic [DELAY_W-1:0]        delay_ff;

   // delay line memory and its bookkeeping
   logic signed [SAMPLE_W-1:0] dly_mem [MAX_DELAY];
   logic signed [SAMPLE_W-1:0] rd_data_ff;
   logic                       rd_ok_ff;
   logic [PTR_W-1:0]           wptr_ff;
   logic [CNT_W-1:0]           fill_cnt_ff;
   logic [CNT_W-1:0]           k_eff;
   logic [31:0]                rd_addr_wide;
   logic [PTR_W-1:0]           rd_addr;

   logic signed [SAMPLE_W-1:0] in_hist_ff  [NUM_INPUT_TAPS];
   logic signed [SAMPLE_W-1:0] out_hist_ff [NUM_OUTPUT_TAPS];

   state_type                 state_ff, state_in;
   logic [TAP_W-1:0]          tap_cnt_ff, tap_cnt_in;

   logic                      req_fire;
   logic                      hist_shift;
   logic                      finish;
   mac_ctrl_type              mac_ctrl;
   logic signed [SAMPLE_W-1:0] op_sample;
   logic signed [COEF_W-1:0]  op_coef;
   logic signed [ACC_W-1:0]   acc;
   logic [ACC_W-1:FRAC_SHIFT+SAMPLE_W-1] acc_hi;
   logic                      over;
   logic signed [SAMPLE_W-1:0] y_val;

   logic                      rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_output_ff;
   logic                      rsp_sat_ff;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEF; i++) begin
            b_coef_ff[i] <= '0;
            a_coef_ff[i] <= '0;
         end
         delay_ff <= DELAY_W'(1);
      end else if (csr_write) begin
         case (csr_index)
            REG_INPUT_COEF_0:    b_coef_ff[0] <= csr_wdata;
            REG_INPUT_COEF_1:    b_coef_ff[1] <= csr_wdata;
            REG_INPUT_COEF_2:    b_coef_ff[2] <= csr_wdata;
            REG_OUTPUT_COEF_1:   a_coef_ff[0] <= csr_wdata;
            REG_OUTPUT_COEF_2:   a_coef_ff[1] <= csr_wdata;
            REG_OUTPUT_COEF_3:   a_coef_ff[2] <= csr_wdata;
            REG_TRANSPORT_DELAY: delay_ff <= csr_wdata[DELAY_W-1:0];
            default: ;
         endcase
      end
   end

   // zero acts as one, anything past the line length as the full length
   always_comb begin
      if (delay_ff == '0) begin
         k_eff = CNT_W'(1);
      end else if (32'(delay_ff) > 32'(MAX_DELAY)) begin
         k_eff = CNT_W'(MAX_DELAY);
      end else begin
         k_eff = CNT_W'(delay_ff);
      end
   end

   // ---------------- delay line ----------------
   assign req_fire = req_valid && !req_stall;

   always_comb begin
      if (32'(wptr_ff) >= 32'(k_eff)) begin
         rd_addr_wide = 32'(wptr_ff) - 32'(k_eff);
      end else begin
         rd_addr_wide = 32'(wptr_ff) + 32'(MAX_DELAY) - 32'(k_eff);
      end
   end
   assign rd_addr = PTR_W'(rd_addr_wide);

   // read sees the old contents when k equals the line length
   always_ff @(posedge clock) begin
      if (req_fire) begin
         dly_mem[wptr_ff] <= req_control_sample;
         rd_data_ff       <= dly_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff     <= '0;
         fill_cnt_ff <= '0;
         rd_ok_ff    <= 1'b0;
      end else if (req_fire) begin
         // entries never written read as zero
         rd_ok_ff <= (fill_cnt_ff >= k_eff);
         if (32'(wptr_ff) == 32'(MAX_DELAY - 1)) begin
            wptr_ff <= '0;
         end else begin
            wptr_ff <= wptr_ff + PTR_W'(1);
         end
         if (32'(fill_cnt_ff) < 32'(MAX_DELAY)) begin
            fill_cnt_ff <= fill_cnt_ff + CNT_W'(1);
         end
      end
   end

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         tap_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         tap_cnt_ff <= tap_cnt_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      tap_cnt_in    = tap_cnt_ff;
      req_stall     = 1'b1;
      mac_ctrl      = '0;
      hist_shift    = 1'b0;
      finish        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall     = 1'b0;
            mac_ctrl.clear = req_valid;
            if (req_valid) begin
               state_in   = ST_MAC;
               tap_cnt_in = '0;
            end
         end
         ST_MAC: begin
            // output taps go first, so the delayed sample lands in time
            mac_ctrl.issue = 1'b1;
            mac_ctrl.sub   = (32'(tap_cnt_ff) < 32'(NUM_OUTPUT_TAPS));
            hist_shift     = (tap_cnt_ff == '0);
            if (32'(tap_cnt_ff) == 32'(NUM_TAPS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               tap_cnt_in = tap_cnt_ff + TAP_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------- operand selection ----------------
   always_comb begin
      logic [31:0] in_idx;
      logic [31:0] out_idx;
      in_idx  = 32'(tap_cnt_ff) - 32'(NUM_OUTPUT_TAPS);
      out_idx = 32'(tap_cnt_ff);
      op_sample = '0;
      op_coef   = '0;
      if (out_idx < 32'(NUM_OUTPUT_TAPS)) begin
         op_sample = out_hist_ff[OH_W'(out_idx)];
         if (out_idx < 32'(NUM_COEF)) begin
            op_coef = a_coef_ff[COEF_IDX_W'(out_idx)];
         end
      end else begin
         op_sample = in_hist_ff[IH_W'(in_idx)];
         if (in_idx < 32'(NUM_COEF)) begin
            op_coef = b_coef_ff[COEF_IDX_W'(in_idx)];
         end
      end
   end

   amf_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .sample (op_sample),
      .coef   (op_coef),
      .acc    (acc)
   );

   // ---------------- rounding and clamp ----------------
   assign acc_hi = acc[ACC_W-1:FRAC_SHIFT+SAMPLE_W-1];
   assign over   = !((&acc_hi) || (~|acc_hi));

   always_comb begin
      if (over) begin
         y_val = acc[ACC_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
      end else begin
         y_val = acc[FRAC_SHIFT+SAMPLE_W-1:FRAC_SHIFT];
      end
   end

   // ---------------- histories ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_INPUT_TAPS; i++) begin
            in_hist_ff[i] <= '0;
         end
      end else if (hist_shift) begin
         for (int i = NUM_INPUT_TAPS - 1; i > 0; i--) begin
            in_hist_ff[i] <= in_hist_ff[i-1];
         end
         in_hist_ff[0] <= rd_ok_ff ? rd_data_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_OUTPUT_TAPS; i++) begin
            out_hist_ff[i] <= '0;
         end
      end else if (finish) begin
         for (int i = NUM_OUTPUT_TAPS - 1; i > 0; i--) begin
            out_hist_ff[i] <= out_hist_ff[i-1];
         end
         out_hist_ff[0] <= y_val;
      end
   end

   // ---------------- result word ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_output_ff <= y_val;
         rsp_sat_ff    <= over;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_plant_output = rsp_output_ff;
   assign rsp_saturated    = rsp_sat_ff;

endmodule

`default_nettype wire

@@ tb/sv/arx_model_filter_core_test.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the arx model filter core with its own plant predictor

module arx_model_filter_core_test;
   import amf_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 20;
   localparam int DELAY_DEPTH  = 16;
   localparam int TAPS         = 3;
   localparam int PHASES       = 8;
   localparam int PHASE_WORDS  = 57;

   // index with no register behind it
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   localparam logic [COEF_W-1:0] COEF_MAX  = 18'h1FFFF;
   localparam logic [COEF_W-1:0] COEF_MIN  = 18'h20000;
   localparam logic [COEF_W-1:0] COEF_ONE  = 18'h10000;
   localparam logic [COEF_W-1:0] COEF_ZERO = 18'h00000;
   localparam logic signed [SAMPLE_W-1:0] U_MAX = SAMPLE_MAX;
   localparam logic signed [SAMPLE_W-1:0] U_MIN = SAMPLE_MIN;
   localparam longint CLIP_HI = 64'sd8388607;
   localparam longint CLIP_LO = -64'sd8388608;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] plant_output;
      logic                       saturated;
   } plant_word_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_control_sample;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [SAMPLE_W-1:0] rsp_plant_output;
   logic                       rsp_saturated;
   logic                       csr_write;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [COEF_W-1:0]          csr_wdata;

   // predictor state
   logic signed [SAMPLE_W-1:0] held_samples [DELAY_DEPTH];
   logic signed [SAMPLE_W-1:0] taps_in [TAPS];
   logic signed [SAMPLE_W-1:0] taps_out [TAPS];
   logic signed [COEF_W-1:0]   num_coef [TAPS];
   logic signed [COEF_W-1:0]   den_coef [TAPS];
   logic [DELAY_W-1:0]         delay_reg;

   plant_word_type expected_words [$];

   bit idling = 1'b1;
   int fail_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   int clip_count = 0;
   int settings_count = 0;
   int cycle_count = 0;

   arx_model_filter_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_control_sample (req_control_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_plant_output   (rsp_plant_output),
      .rsp_saturated      (rsp_saturated),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run stopped after %0d cycles", $time, cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic clear_model();
      int i;
      for (i = 0; i < DELAY_DEPTH; i++) held_samples[i] = '0;
      for (i = 0; i < TAPS; i++) begin
         taps_in[i] = '0;
         taps_out[i] = '0;
         num_coef[i] = '0;
         den_coef[i] = '0;
      end
      delay_reg = 5'd1;
   endtask

   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [COEF_W-1:0] data);
      case (idx)
         REG_INPUT_COEF_0:    num_coef[0] = data;
         REG_INPUT_COEF_1:    num_coef[1] = data;
         REG_INPUT_COEF_2:    num_coef[2] = data;
         REG_OUTPUT_COEF_1:   den_coef[0] = data;
         REG_OUTPUT_COEF_2:   den_coef[1] = data;
         REG_OUTPUT_COEF_3:   den_coef[2] = data;
         REG_TRANSPORT_DELAY: delay_reg = data[DELAY_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic plant_word_type predict_plant(input logic signed [SAMPLE_W-1:0] u);
      plant_word_type word;
      int k;
      int i;
      logic signed [SAMPLE_W-1:0] delayed;
      longint acc;
      longint y;
      // zero acts as one, anything past the line depth reads the oldest slot
      if (delay_reg == 0) k = 1;
      else if (delay_reg > DELAY_DEPTH) k = DELAY_DEPTH;
      else k = delay_reg;
      delayed = held_samples[k-1];
      for (i = DELAY_DEPTH - 1; i > 0; i--) held_samples[i] = held_samples[i-1];
      held_samples[0] = u;
      for (i = TAPS - 1; i > 0; i--) taps_in[i] = taps_in[i-1];
      taps_in[0] = delayed;
      acc = 0;
      for (i = 0; i < TAPS; i++) begin
         acc += longint'(num_coef[i]) * longint'(taps_in[i]);
         acc -= longint'(den_coef[i]) * longint'(taps_out[i]);
      end
      // round half up, then clip to the sample range
      y = (acc + 64'sd32768) >>> 16;
      word.saturated = 1'b0;
      if (y > CLIP_HI) begin
         y = CLIP_HI;
         word.saturated = 1'b1;
      end else if (y < CLIP_LO) begin
         y = CLIP_LO;
         word.saturated = 1'b1;
      end
      word.plant_output = y[SAMPLE_W-1:0];
      for (i = TAPS - 1; i > 0; i--) taps_out[i] = taps_out[i-1];
      taps_out[0] = word.plant_output;
      return word;
   endfunction

   function automatic logic [COEF_W-1:0] rand_coef(input bit gentle);
      if (gentle) return COEF_W'(int'($urandom_range(0, 16383)) - 8192);
      return COEF_W'($urandom);
   endfunction

   function automatic logic [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(0, 9))
         0: return U_MAX;
         1: return U_MIN;
         2, 3: return SAMPLE_W'(int'($urandom_range(0, 65535)) - 32768);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // receiver side: random stall bursts while idling is on
   initial begin
      int burst;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (idling && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 19);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      plant_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $display("%0t: output word with nothing expected, got %0d sat %b",
                     $time, rsp_plant_output, rsp_saturated);
            fail_count++;
         end else begin
            want = expected_words.pop_front();
            checked_count++;
            if (want.saturated) clip_count++;
            if (rsp_plant_output !== want.plant_output) begin
               $display("%0t: plant_output expected %0d, got %0d",
                        $time, want.plant_output, rsp_plant_output);
               fail_count++;
            end
            if (rsp_saturated !== want.saturated) begin
               $display("%0t: saturated expected %b, got %b",
                        $time, want.saturated, rsp_saturated);
               fail_count++;
            end
         end
      end
   end

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] u);
      int gap;
      if (idling && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_control_sample <= u;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_words.push_back(predict_plant(u));
      sent_count++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      apply_csr(idx, data);
   endtask

   task automatic set_model(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                            input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] a1,
                            input logic [COEF_W-1:0] a2, input logic [COEF_W-1:0] a3,
                            input logic [COEF_W-1:0] delay_word);
      wait_idle();
      write_csr(REG_INPUT_COEF_0, b0);
      write_csr(REG_INPUT_COEF_1, b1);
      write_csr(REG_INPUT_COEF_2, b2);
      write_csr(REG_OUTPUT_COEF_1, a1);
      write_csr(REG_OUTPUT_COEF_2, a2);
      write_csr(REG_OUTPUT_COEF_3, a3);
      write_csr(REG_TRANSPORT_DELAY, delay_word);
      settings_count++;
   endtask

   // all coefficients zero after reset, so every word must be zero
   task automatic test_reset_state();
      send_sample(U_MAX);
      send_sample(U_MIN);
      send_sample(-24'sd1);
   endtask

   task automatic test_pass_through();
      set_model(COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO, 18'd1);
      // the unused index must leave every register alone
      write_csr(REG_UNUSED, 18'h3FFFF);
      send_sample(U_MAX);
      send_sample(U_MIN);
      send_sample(24'sd0);
      send_sample(24'sd1);
   endtask

   task automatic test_delay_range();
      set_model(COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO, 18'd0);
      send_sample(24'sd100);
      send_sample(24'sd200);
      // longer delay reaches past the words written so far, which read as zero
      wait_idle();
      write_csr(REG_TRANSPORT_DELAY, 18'd16);
      send_sample(24'sd300);
      send_sample(-24'sd400);
      // upper data bits ignored, 31 clamps to the line depth
      wait_idle();
      write_csr(REG_TRANSPORT_DELAY, 18'h3FFFF);
      send_sample(24'sd500);
      wait_idle();
      write_csr(REG_TRANSPORT_DELAY, 18'd17);
      send_sample(-24'sd600);
   endtask

   task automatic test_round_and_clip();
      set_model(COEF_W'(1), COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO, 18'd1);
      send_sample(24'sd32768);
      send_sample(-24'sd32768);
      send_sample(-24'sd32769);
      set_model(COEF_MAX, COEF_MAX, COEF_MAX, COEF_ZERO, COEF_ZERO, COEF_ZERO, 18'd1);
      send_sample(U_MAX);
      send_sample(U_MIN);
      set_model(COEF_MIN, COEF_MIN, COEF_MIN, COEF_ZERO, COEF_ZERO, COEF_ZERO, 18'd1);
      send_sample(U_MIN);
   endtask

   task automatic test_feedback();
      // integrator runs into the clip and keeps the clipped value as history
      set_model(COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_W'(-65536), COEF_ZERO, COEF_ZERO, 18'd1);
      send_sample(U_MAX);
      send_sample(U_MAX);
      send_sample(U_MAX);
      set_model(COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_MAX, COEF_MIN, COEF_MAX, 18'd2);
      send_sample(U_MIN);
      send_sample(24'sd4096);
   endtask

   task automatic test_random_settings();
      int phase;
      bit gentle;
      logic [COEF_W-1:0] delay_word;
      for (phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         // last stretch runs with no gaps and no stalls
         idling = (phase < PHASES - 2);
         gentle = $urandom_range(0, 2) != 0;
         delay_word = COEF_W'($urandom);
         if ($urandom_range(0, 3) != 0) delay_word[DELAY_W-1:0] = DELAY_W'($urandom_range(1, 16));
         if (phase == 0)
            set_model(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, 18'd16);
         else if (phase == 1)
            set_model(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, 18'd1);
         else
            set_model(rand_coef(1'b0), rand_coef(1'b0), rand_coef(1'b0),
                      rand_coef(gentle), rand_coef(gentle), rand_coef(gentle), delay_word);
         if ($urandom_range(0, 1) == 1) write_csr(REG_UNUSED, COEF_W'($urandom));
         repeat (PHASE_WORDS) send_sample(rand_sample());
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_control_sample <= '0;
      csr_write <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      clear_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_pass_through();
      test_delay_range();
      test_round_and_clip();
      test_feedback();
      test_random_settings();
      wait_idle();
      $display("checked %0d output words from %0d samples over %0d register settings",
               checked_count, sent_count, settings_count);
      $display("%0d of those words were clipped to the sample range", clip_count);
      if (fail_count == 0 && expected_words.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
